>>> src/masked_window_mean_filter_defines.svh
// ----------------------------------------------------------------------------
// masked_window_mean_filter_defines
// Assertion macros used by the masked window mean filter checker.
// ----------------------------------------------------------------------------
`ifndef MASKED_WINDOW_MEAN_FILTER_DEFINES_SVH
`define MASKED_WINDOW_MEAN_FILTER_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet while arst_n is low
`define MWMF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("masked window mean filter: check failed");

// next-cycle implication, clocked on clk, quiet while arst_n is low
`define MWMF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("masked window mean filter: check failed");

`endif

>>> src/mwmf_pkg.sv
// ----------------------------------------------------------------------------
// mwmf_pkg
// Types and fixed widths of the masked window mean filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mwmf_pkg;

	localparam int CFG_W      = 11;
	localparam int PIX_W      = 8;
	localparam int TAP_CNT_W  = 8;
	localparam int MASK_BITS  = 225;
	localparam int SUM_W      = 16;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int MASK3_W    = 33;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_MASK_WORD0   = 3'd2,
		REG_MASK_WORD1   = 3'd3,
		REG_MASK_WORD2   = 3'd4,
		REG_MASK_WORD3   = 3'd5,
		REG_TAP_COUNT    = 3'd6
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DEC,
		ST_WMOD,
		ST_CHK,
		ST_BMOD,
		ST_TAP,
		ST_TAIL,
		ST_DIVGO,
		ST_DIV,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic             mode;
		logic [PIX_W-1:0] pixel;
	} in_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] filtered_pixel;
		logic             frame_last;
	} out_word_t;

endpackage

>>> src/mwmf_ram.sv
// ----------------------------------------------------------------------------
// mwmf_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/mwmf_mod.sv
// ----------------------------------------------------------------------------
// mwmf_mod
// Remainder by a constant modulus through a reciprocal multiply, in registered steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwmf_mod #(
	parameter int XW  = 25,
	parameter int MOD = 14351
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [XW-1:0]          x,
	output logic                   done,
	output logic [$clog2(MOD)-1:0] rem
);

	localparam int AW = $clog2(MOD);
	localparam int SH = XW + AW;
	localparam int MW = XW + 2;
	localparam int PW = XW + MW;
	localparam int QW = PW - SH;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(MOD) - 64'd1) / 64'(MOD);
	localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

	logic [XW-1:0] x_s1, x_s2;
	logic [PW-1:0] prod_s2;
	logic          v_s1, v_s2;
	logic          done_q;
	logic [AW-1:0] rem_q;
	logic [QW-1:0] quo;
	logic [XW-1:0] back;
	logic [XW-1:0] diff;

	// quotient from the reciprocal, then the remainder left over
	assign quo  = prod_s2[PW-1:SH];
	assign back = XW'(quo) * XW'(MOD);
	assign diff = x_s2 - back;

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	// hold the operand, multiply by the reciprocal, subtract back
	always_ff @(posedge clk) begin
		if (start) begin
			x_s1 <= x;
		end
		if (v_s1) begin
			prod_s2 <= PW'(x_s1) * PW'(RECIP_C);
			x_s2    <= x_s1;
		end
		if (v_s2) begin
			rem_q <= diff[AW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> src/mwmf_div.sv
// ----------------------------------------------------------------------------
// mwmf_div
// Restoring divider of the window sum by the tap count, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwmf_div import mwmf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SUM_W-1:0]     dividend,
	input  logic [TAP_CNT_W-1:0] divisor,
	output logic                 done,
	output logic [SUM_W-1:0]     quotient
);

	localparam int CW = $clog2(SUM_W);

	logic [SUM_W-1:0]     quo_q;
	logic [TAP_CNT_W-1:0] rem_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [TAP_CNT_W:0]   trial;
	logic [TAP_CNT_W:0]   diff;
	logic                 qbit;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign qbit  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(SUM_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], qbit};
			rem_q <= qbit ? diff[TAP_CNT_W-1:0] : trial[TAP_CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> src/masked_window_mean_filter.sv
// ----------------------------------------------------------------------------
// masked_window_mean_filter: one word at a time; a word that yields a result
// walks every tap of the window, reading the line store for each tap inside
// the frame, then runs the serial divider and waits out any output stall;
// a pixel word that falls inside the frame first writes it to the line store.
// Reset clears the configuration, the sequencer and the position counters
// at once; the payload registers and the line store are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module masked_window_mean_filter import mwmf_pkg::*; #(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_HEIGHT  = 1024,
	parameter int WINDOW_SIZE = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_data
);

	localparam int HALF  = WINDOW_SIZE / 2;
	localparam int DEPTH = (WINDOW_SIZE - 1) * MAX_WIDTH + WINDOW_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int XW    = CFG_W + ((WW > HW) ? WW : HW) + 1;
	localparam int KW    = $clog2(WINDOW_SIZE);
	localparam int TW    = $clog2(WINDOW_SIZE * WINDOW_SIZE);
	localparam int RW    = CFG_W + 3;

	// configuration
	logic [CFG_W-1:0]      cfg_width_q;
	logic [CFG_W-1:0]      cfg_height_q;
	logic [CFG_DATA_W-1:0] mask0_q, mask1_q, mask2_q;
	logic [MASK3_W-1:0]    mask3_q;
	logic [TAP_CNT_W-1:0]  tap_count_q;

	// sequencer and counters
	seq_state_t       state_q, state_d;
	logic [CFG_W-1:0] in_row_q, in_col_q, out_row_q, out_col_q;
	logic             mode_q;
	logic [PIX_W-1:0] pix_q;
	logic [XW-1:0]    rin_q, rout_q, total_q, delay_q, rin_e, mod_x;
	logic [KW-1:0]    kr_q, kc_q;
	logic [AW-1:0]    addr_q;
	logic [SUM_W-1:0] sum_q;
	logic             en_s1;
	logic [PIX_W-1:0] res_q;
	logic             out_valid_q;
	out_word_t        out_data_q;

	logic [WW-1:0]        w_c;
	logic [HW-1:0]        h_c;
	logic [MASK_BITS-1:0] mask_all;
	logic [TW-1:0]        tap_idx;
	logic                 frame_rst, due, last_c, take_out, in_frame;
	logic                 kc_last, kr_last, in_wrap, out_wrap;
	logic signed [RW-1:0] rr_c, cc_c;
	logic [AW:0]          ainc;
	logic [AW-1:0]        a_col;
	logic signed [AW+1:0] arow, bdiff;
	logic [AW-1:0]        a_row, base_c;

	logic                 mod_start, mod_done;
	logic [AW-1:0]        mod_rem;
	logic                 div_start, div_done;
	logic [SUM_W-1:0]     div_quo;
	logic                 ram_we, ram_re;
	logic [PIX_W-1:0]     ram_rdata;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= CFG_W'(1024);
			cfg_height_q <= CFG_W'(1024);
			mask0_q      <= '0;
			mask1_q      <= '0;
			mask2_q      <= '0;
			mask3_q      <= '0;
			tap_count_q  <= '0;
		end else if (cfg_write) begin
			unique case (reg_index_t'(cfg_index))
				REG_FRAME_WIDTH:  cfg_width_q  <= cfg_data[CFG_W-1:0];
				REG_FRAME_HEIGHT: cfg_height_q <= cfg_data[CFG_W-1:0];
				REG_MASK_WORD0:   mask0_q      <= cfg_data;
				REG_MASK_WORD1:   mask1_q      <= cfg_data;
				REG_MASK_WORD2:   mask2_q      <= cfg_data;
				REG_MASK_WORD3:   mask3_q      <= cfg_data[MASK3_W-1:0];
				REG_TAP_COUNT:    tap_count_q  <= cfg_data[TAP_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp frame size to 1..max
	always_comb begin
		if (cfg_width_q == '0) begin
			w_c = WW'(1);
		end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(cfg_width_q);
		end
		if (cfg_height_q == '0) begin
			h_c = HW'(1);
		end else if (32'(cfg_height_q) > 32'(MAX_HEIGHT)) begin
			h_c = HW'(MAX_HEIGHT);
		end else begin
			h_c = HW'(cfg_height_q);
		end
	end

	assign mask_all = {mask3_q, mask2_q, mask1_q, mask0_q};
	assign tap_idx  = TW'(32'(kr_q) * WINDOW_SIZE + 32'(kc_q));

	// frame bookkeeping
	assign frame_rst = (rin_q >= total_q) && (rout_q >= total_q);
	assign rin_e     = frame_rst ? '0 : rin_q;
	assign due       = (rout_q < total_q) &&
		((rin_q >= total_q) || ({1'b0, rin_q} > ({1'b0, rout_q} + {1'b0, delay_q})));
	assign last_c    = (rout_q + XW'(1)) == total_q;
	assign take_out  = !out_valid_q || !out_stall;
	assign in_wrap   = (32'(in_col_q) + 32'd1) >= 32'(w_c);
	assign out_wrap  = (32'(out_col_q) + 32'd1) >= 32'(w_c);
	assign mod_x     = (state_q == ST_DEC) ? rin_e : rout_q;

	// tap position inside the frame
	assign rr_c     = $signed(RW'(out_row_q)) + $signed(RW'(kr_q)) - $signed(RW'(HALF));
	assign cc_c     = $signed(RW'(out_col_q)) + $signed(RW'(kc_q)) - $signed(RW'(HALF));
	assign in_frame = (rr_c >= 0) && (rr_c < $signed(RW'(h_c))) &&
		(cc_c >= 0) && (cc_c < $signed(RW'(w_c)));
	assign kc_last  = kc_q == KW'(WINDOW_SIZE - 1);
	assign kr_last  = kr_q == KW'(WINDOW_SIZE - 1);

	// store address: next column, next row, window origin
	assign ainc  = {1'b0, addr_q} + 1'b1;
	assign a_col = (ainc >= (AW+1)'(DEPTH)) ? AW'(ainc - (AW+1)'(DEPTH)) : AW'(ainc);
	assign arow  = $signed({2'b00, addr_q}) + $signed((AW+2)'(w_c))
		- $signed((AW+2)'(WINDOW_SIZE - 1));
	always_comb begin
		if (arow < 0) begin
			a_row = AW'(arow + $signed((AW+2)'(DEPTH)));
		end else if (arow >= $signed((AW+2)'(DEPTH))) begin
			a_row = AW'(arow - $signed((AW+2)'(DEPTH)));
		end else begin
			a_row = AW'(arow);
		end
	end
	assign bdiff  = $signed({2'b00, mod_rem}) - $signed((AW+2)'(delay_q[AW-1:0]));
	assign base_c = (bdiff < 0) ? AW'(bdiff + $signed((AW+2)'(DEPTH))) : AW'(bdiff);

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		mod_start = 1'b0;
		div_start = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_DEC;
			ST_DEC: begin
				if ((mode_q == MODE_PIXEL) && (rin_e < total_q)) begin
					mod_start = 1'b1;
					state_d   = ST_WMOD;
				end else begin
					state_d = ST_CHK;
				end
			end
			ST_WMOD: begin
				if (mod_done) begin
					ram_we  = 1'b1;
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (due) begin
					mod_start = 1'b1;
					state_d   = ST_BMOD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_BMOD: begin
				if (mod_done) begin
					state_d = ST_TAP;
				end
			end
			ST_TAP: begin
				ram_re = in_frame;
				if (kc_last && kr_last) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: state_d = ST_DIVGO;
			ST_DIVGO: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (take_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state: sequencer, position counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_row_q    <= '0;
			in_col_q    <= '0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			en_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			en_s1   <= (state_q == ST_TAP) && in_frame && mask_all[tap_idx];
			if ((state_q == ST_DEC) && frame_rst) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end
			if ((state_q == ST_WMOD) && mod_done) begin
				if (in_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if ((state_q == ST_OUT) && take_out) begin
				out_valid_q <= 1'b1;
				if (last_c && (rin_q >= total_q)) begin
					in_row_q  <= '0;
					in_col_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
				end else if (out_wrap) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: linear positions, window walk, sum, result
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					mode_q <= in_data.mode;
					pix_q  <= in_data.pixel;
				end
			end
			ST_MUL: begin
				rin_q   <= XW'(in_row_q) * XW'(w_c) + XW'(in_col_q);
				rout_q  <= XW'(out_row_q) * XW'(w_c) + XW'(out_col_q);
				total_q <= XW'(w_c) * XW'(h_c);
				delay_q <= XW'(HALF) * XW'(w_c) + XW'(HALF);
			end
			ST_DEC: begin
				if (frame_rst) begin
					rin_q  <= '0;
					rout_q <= '0;
				end
			end
			ST_WMOD: begin
				if (mod_done) begin
					rin_q <= rin_q + XW'(1);
				end
			end
			ST_BMOD: begin
				if (mod_done) begin
					addr_q <= base_c;
					kr_q   <= '0;
					kc_q   <= '0;
					sum_q  <= '0;
				end
			end
			ST_TAP: begin
				if (en_s1) begin
					sum_q <= sum_q + SUM_W'(ram_rdata);
				end
				if (kc_last) begin
					kc_q   <= '0;
					kr_q   <= kr_q + 1'b1;
					addr_q <= a_row;
				end else begin
					kc_q   <= kc_q + 1'b1;
					addr_q <= a_col;
				end
			end
			ST_TAIL: begin
				if (en_s1) begin
					sum_q <= sum_q + SUM_W'(ram_rdata);
				end
			end
			ST_DIV: begin
				if (div_done) begin
					if (tap_count_q == '0) begin
						res_q <= '0;
					end else if (|div_quo[SUM_W-1:PIX_W]) begin
						res_q <= '1;
					end else begin
						res_q <= div_quo[PIX_W-1:0];
					end
				end
			end
			ST_OUT: begin
				if (take_out) begin
					out_data_q.filtered_pixel <= res_q;
					out_data_q.frame_last     <= last_c;
				end
			end
			default: ;
		endcase
	end

	mwmf_mod #(
		.XW  (XW),
		.MOD (DEPTH)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.x      (mod_x),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	mwmf_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (mod_rem),
		.wdata (pix_q),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	mwmf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (tap_count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> src/mwmf_checker.sv
// ----------------------------------------------------------------------------
// mwmf_checker
// Port-level checks of the masked window mean filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "masked_window_mean_filter_defines.svh"

module mwmf_checker import mwmf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_data
);

	// a taken word keeps the block busy on the next cycle
	`MWMF_ASSERT_NEXT(a_take_blocks, in_valid && !in_stall, in_stall)

	// a new result only appears out of a busy stretch
	`MWMF_ASSERT_NOW(a_out_from_work, $rose(out_valid), $past(in_stall))

	// hold a stalled result word
	`MWMF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind masked_window_mean_filter mwmf_checker u_mwmf_checker (.*);
